>>> rtl/windowed_trend_prodrome_scorer_defines.svh
// Assertion macros used by the checker file of the trend scorer.
`ifndef WINDOWED_TREND_PRODROME_SCORER_DEFINES_SVH
`define WINDOWED_TREND_PRODROME_SCORER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WTPS_ASSERT_IMP(name, pre, con, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WTPS_ASSERT_NXT(name, pre, con, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error(msg);

`endif

>>> rtl/wtps_pkg.sv
// Types and constants of the windowed trend prodrome scorer.
`default_nettype none

package wtps_pkg;

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_AW    = 4;
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_EDA_THR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_THR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HR_THR   = 2'd2;

  typedef logic signed [23:0] thr_t;

  localparam thr_t EDA_THR_RST  = 24'sd65536;
  localparam thr_t TEMP_THR_RST = -24'sd41943;
  localparam thr_t HR_THR_RST   = 24'sd104858;

  // Channel lanes
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_TEMP = 0;
  localparam int unsigned LANE_EDA  = 1;
  localparam int unsigned LANE_HR   = 2;

  // Lane sample value, wide enough for signed temperature and unsigned conductance
  localparam int unsigned VAL_W = 17;

  // Slope compare: num*2^16 vs thr*den scaled by 12/N gives 3*D*2^17 vs thr*N*(N^2-1)
  localparam int unsigned SLOPE_Q_SHIFT = 17;

  // Scoring in percent
  localparam logic [6:0] SCORE_EDA    = 7'd40;
  localparam logic [6:0] SCORE_TEMP   = 7'd30;
  localparam logic [6:0] SCORE_HR     = 7'd30;
  localparam logic [6:0] ALERT_LEVEL  = 7'd65;
  localparam logic [9:0] LEAD_PER_PCT = 10'd6;

  // Result queue
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = 3;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [15:0]        conductance;
    logic [11:0]        heart_rate;
  } sample_t;

  typedef struct packed {
    logic       alert;
    logic [6:0] probability_pct;
    logic [9:0] lead_seconds;
    logic       eda_rising;
    logic       temp_falling;
    logic       hr_rising;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/windowed_trend_prodrome_scorer.sv
// Top level of the windowed trend prodrome scorer.
// Usage:
//   Input channel (in_valid / in_stall): in_command 0 writes one sample of each
//   channel into the window and gives no result; in_command 1 evaluates the
//   three window slopes against their thresholds and gives one result.
//   Result channel (out_valid / out_stall): alert, percent, lead time and the
//   three trend flags of each evaluate, in order.
//   Configuration: APB-style writes to the three slope thresholds at 0, 4, 8;
//   write them only while no evaluate is outstanding.
// Throughput: one transaction per cycle while in_stall is low. A sample reads
//   its oldest slot in the window memory in the cycle it is taken and writes it
//   back with the updated running sums in the next; that read / write-back pair
//   is pipelined. An evaluate passes stage 1, E1, E2 and E3 and is then written
//   into the result queue, where out_valid shows it.
// Stall: results wait in an 8-entry queue; in_stall rises only when eight
//   evaluate results are outstanding, and samples keep flowing otherwise.
// Reset: sums, write pointer and queue clear, thresholds return to defaults.
//   The window needs no clearing pass: slots read in the first pass after reset
//   count as zero.
`default_nettype none

module windowed_trend_prodrome_scorer
  import wtps_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 600
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_command,
  input  wire logic signed [15:0]  in_temperature,
  input  wire logic [15:0]         in_conductance,
  input  wire logic [11:0]         in_heart_rate,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_alert,
  output logic [6:0]               out_probability_pct,
  output logic [9:0]               out_lead_seconds,
  output logic                     out_eda_rising,
  output logic                     out_temp_falling,
  output logic                     out_hr_rising,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned L       = $clog2(WINDOW_LEN);
  localparam int unsigned PSUM_W  = L + 17;
  localparam int unsigned WSUM_W  = 2 * L + 16;
  localparam int unsigned MP_W    = 2 * L + 17;
  localparam int unsigned D_W     = 2 * L + 18;
  localparam int unsigned LHS_W   = D_W + 2 + SLOPE_Q_SHIFT;
  localparam int unsigned KW      = 3 * L;
  localparam int unsigned KLO_W   = (KW + 1) / 2;
  localparam int unsigned KHI_W   = KW - KLO_W;
  localparam int unsigned PL_W    = 24 + KLO_W + 1;
  localparam int unsigned PH_W    = 24 + KHI_W + 1;
  localparam int unsigned RHS_W   = 24 + KW + 1;
  localparam int unsigned CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam logic [L-1:0]       PTR_LAST = L'(WINDOW_LEN - 1);
  localparam logic signed [L:0]  NM1      = (L + 1)'(WINDOW_LEN - 1);
  localparam logic [63:0] K64 =
    64'(WINDOW_LEN) * (64'(WINDOW_LEN) * 64'(WINDOW_LEN) - 64'd1);
  localparam logic [KLO_W-1:0] K_LO = K64[KLO_W-1:0];
  localparam logic [KHI_W-1:0] K_HI = KHI_W'(K64 >> KLO_W);

  // ---------------------------------------------------------------------------
  // Configuration registers
  thr_t eda_thr_r, temp_thr_r, hr_thr_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eda_thr_r  <= EDA_THR_RST;
      temp_thr_r <= TEMP_THR_RST;
      hr_thr_r   <= HR_THR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_W+1:2])
        REG_EDA_THR:  eda_thr_r  <= pwdata[23:0];
        REG_TEMP_THR: temp_thr_r <= pwdata[23:0];
        REG_HR_THR:   hr_thr_r   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_W+1:2])
      REG_EDA_THR:  prdata = {{8{eda_thr_r[23]}}, eda_thr_r};
      REG_TEMP_THR: prdata = {{8{temp_thr_r[23]}}, temp_thr_r};
      REG_HR_THR:   prdata = {{8{hr_thr_r[23]}}, hr_thr_r};
      default:      prdata = '0;
    endcase
  end

  thr_t lane_thr [NUM_LANES];
  assign lane_thr[LANE_TEMP] = temp_thr_r;
  assign lane_thr[LANE_EDA]  = eda_thr_r;
  assign lane_thr[LANE_HR]   = hr_thr_r;

  // ---------------------------------------------------------------------------
  // Input handshake and stage 1 (memory read)
  logic [OQ_AW:0] eval_cnt_r, eval_cnt_nxt;
  logic           in_fire, out_fire;

  assign in_stall = (eval_cnt_r == (OQ_AW + 1)'(OQ_DEPTH));
  assign in_fire  = in_valid & ~in_stall;

  logic [L-1:0] ptr_r, ptr_nxt;
  logic         full_r;
  logic         s1_vld_r, s1_cmd_r, s1_oldv_r;
  logic [L-1:0] s1_ptr_r;
  sample_t      s1_smp_r;
  sample_t      rd_data_r;
  logic         s1_sample, s1_eval;

  assign ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + L'(1);
  assign s1_sample = s1_vld_r & (s1_cmd_r == CMD_SAMPLE);
  assign s1_eval   = s1_vld_r & (s1_cmd_r == CMD_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      full_r   <= 1'b0;
      s1_vld_r <= 1'b0;
      s1_cmd_r <= CMD_SAMPLE;
    end else begin
      s1_vld_r <= in_fire;
      s1_cmd_r <= in_command;
      if (in_fire && in_command == CMD_SAMPLE) begin
        ptr_r <= ptr_nxt;
        if (ptr_r == PTR_LAST) full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ptr_r                 <= ptr_r;
    s1_oldv_r                <= full_r;
    s1_smp_r.temperature     <= in_temperature;
    s1_smp_r.conductance     <= in_conductance;
    s1_smp_r.heart_rate      <= in_heart_rate;
  end

  // Window memory: read the slot at the pointer, write it back in the next cycle.
  // Back-to-back samples touch consecutive slots, so read and write never collide.
  sample_t win_mem [WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (s1_sample) win_mem[s1_ptr_r] <= s1_smp_r;
    rd_data_r <= win_mem[ptr_r];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: running sums
  logic signed [VAL_W-1:0]  new_val [NUM_LANES];
  logic signed [VAL_W-1:0]  old_val [NUM_LANES];
  logic signed [PSUM_W-1:0] psum_r  [NUM_LANES];
  logic signed [PSUM_W-1:0] psum_nxt[NUM_LANES];
  logic signed [PSUM_W-1:0] diff    [NUM_LANES];
  logic signed [WSUM_W-1:0] wsum_r  [NUM_LANES];
  logic signed [WSUM_W-1:0] wsum_nxt[NUM_LANES];
  logic signed [WSUM_W-1:0] wprod   [NUM_LANES];
  logic signed [MP_W-1:0]   pmul    [NUM_LANES];
  sample_t                  old_smp;

  // Slots not yet written since reset read as zero
  assign old_smp = s1_oldv_r ? rd_data_r : '0;

  always_comb begin
    new_val[LANE_TEMP] = {s1_smp_r.temperature[15], s1_smp_r.temperature};
    new_val[LANE_EDA]  = {1'b0, s1_smp_r.conductance};
    new_val[LANE_HR]   = {5'b0, s1_smp_r.heart_rate};
    old_val[LANE_TEMP] = {old_smp.temperature[15], old_smp.temperature};
    old_val[LANE_EDA]  = {1'b0, old_smp.conductance};
    old_val[LANE_HR]   = {5'b0, old_smp.heart_rate};
    for (int i = 0; i < NUM_LANES; i++) begin
      diff[i]     = psum_r[i] - PSUM_W'(old_val[i]);
      wprod[i]    = new_val[i] * NM1;
      wsum_nxt[i] = wsum_r[i] - WSUM_W'(diff[i]) + wprod[i];
      psum_nxt[i] = diff[i] + PSUM_W'(new_val[i]);
      pmul[i]     = psum_r[i] * NM1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        psum_r[i] <= '0;
        wsum_r[i] <= '0;
      end
    end else if (s1_sample) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        psum_r[i] <= psum_nxt[i];
        wsum_r[i] <= wsum_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluate pipeline: E1 weighted and scaled plain sums, E2 centered numerator and
  // threshold partial products, E3 both sides of the compare; the score is formed from E3.
  logic e1_vld_r, e2_vld_r, e3_vld_r;

  logic signed [WSUM_W-1:0] e1_w_r   [NUM_LANES];
  logic signed [MP_W-1:0]   e1_pm_r  [NUM_LANES];
  logic signed [D_W-1:0]    e2_d_r   [NUM_LANES];
  logic signed [PL_W-1:0]   e2_pl_r  [NUM_LANES];
  logic signed [PH_W-1:0]   e2_ph_r  [NUM_LANES];
  logic signed [CMP_W-1:0]  lhs3     [NUM_LANES];
  logic signed [CMP_W-1:0]  e3_lhs_r [NUM_LANES];
  logic signed [CMP_W-1:0]  e3_rhs_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= s1_eval;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lhs3[i] = CMP_W'(e2_d_r[i]) + (CMP_W'(e2_d_r[i]) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      e1_w_r[i]   <= wsum_r[i];
      e1_pm_r[i]  <= pmul[i];
      e2_d_r[i]   <= (D_W'(e1_w_r[i]) <<< 1) - D_W'(e1_pm_r[i]);
      e2_pl_r[i]  <= lane_thr[i] * $signed({1'b0, K_LO});
      e2_ph_r[i]  <= lane_thr[i] * $signed({1'b0, K_HI});
      e3_lhs_r[i] <= lhs3[i] <<< SLOPE_Q_SHIFT;
      e3_rhs_r[i] <= (CMP_W'(e2_ph_r[i]) <<< KLO_W) + CMP_W'(e2_pl_r[i]);
    end
  end

  logic       tf, er, hr;
  logic [6:0] score, pct;
  result_t    e3_res;

  always_comb begin
    tf    = e3_lhs_r[LANE_TEMP] < e3_rhs_r[LANE_TEMP];
    er    = e3_lhs_r[LANE_EDA]  > e3_rhs_r[LANE_EDA];
    hr    = e3_lhs_r[LANE_HR]   > e3_rhs_r[LANE_HR];
    score = (er ? SCORE_EDA : 7'd0) + (tf ? SCORE_TEMP : 7'd0) + (hr ? SCORE_HR : 7'd0);
    // Halve a score at or below the alert level; every sum is even
    pct   = (score > ALERT_LEVEL) ? score : (score >> 1);
    e3_res.alert           = score > ALERT_LEVEL;
    e3_res.probability_pct = pct;
    e3_res.lead_seconds    = 10'(pct) * LEAD_PER_PCT;
    e3_res.eda_rising      = er;
    e3_res.temp_falling    = tf;
    e3_res.hr_rising       = hr;
  end

  // ---------------------------------------------------------------------------
  // Result queue; admission is limited by eval_cnt_r so it never overflows
  result_t          oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_AW:0]   oq_cnt_r;
  result_t          oq_head;

  assign out_valid = (oq_cnt_r != '0);
  assign out_fire  = out_valid & ~out_stall;
  assign oq_head   = oq_mem_r[oq_rd_r];

  always_comb begin
    eval_cnt_nxt = eval_cnt_r;
    if (in_fire && in_command == CMD_EVAL) eval_cnt_nxt = eval_cnt_nxt + (OQ_AW + 1)'(1);
    if (out_fire)                           eval_cnt_nxt = eval_cnt_nxt - (OQ_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
      eval_cnt_r <= '0;
    end else begin
      eval_cnt_r <= eval_cnt_nxt;
      if (e3_vld_r) oq_wr_r <= oq_wr_r + OQ_AW'(1);
      if (out_fire) oq_rd_r <= oq_rd_r + OQ_AW'(1);
      case ({e3_vld_r, out_fire})
        2'b10:   oq_cnt_r <= oq_cnt_r + (OQ_AW + 1)'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - (OQ_AW + 1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (e3_vld_r) oq_mem_r[oq_wr_r] <= e3_res;
  end

  assign out_alert           = oq_head.alert;
  assign out_probability_pct = oq_head.probability_pct;
  assign out_lead_seconds    = oq_head.lead_seconds;
  assign out_eda_rising      = oq_head.eda_rising;
  assign out_temp_falling    = oq_head.temp_falling;
  assign out_hr_rising       = oq_head.hr_rising;

endmodule

`default_nettype wire

>>> rtl/wtps_checker.sv
// Port-level checker of the trend scorer and its bind to the top level.
`default_nettype none
`include "windowed_trend_prodrome_scorer_defines.svh"

module wtps_checker
  import wtps_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_alert,
  input wire logic [6:0] out_probability_pct,
  input wire logic [9:0] out_lead_seconds,
  input wire logic       out_eda_rising,
  input wire logic       out_temp_falling,
  input wire logic       out_hr_rising
);

  logic [6:0] exp_score, exp_pct;
  logic [9:0] exp_lead;
  logic       alert_lead_ok;

  always_comb begin
    exp_score = (out_eda_rising   ? SCORE_EDA  : 7'd0)
              + (out_temp_falling ? SCORE_TEMP : 7'd0)
              + (out_hr_rising    ? SCORE_HR   : 7'd0);
    exp_pct   = (exp_score > ALERT_LEVEL) ? exp_score : (exp_score >> 1);
    exp_lead  = 10'(out_probability_pct) * LEAD_PER_PCT;
    alert_lead_ok = (out_alert == (out_probability_pct > ALERT_LEVEL))
                  && (out_lead_seconds == exp_lead);
  end

  `WTPS_ASSERT_IMP(a_pct_from_flags, out_valid, out_probability_pct == exp_pct,
                   "percent does not match trend flags")
  `WTPS_ASSERT_IMP(a_alert_lead, out_valid, alert_lead_ok,
                   "alert or lead time inconsistent with percent")
  `WTPS_ASSERT_IMP(a_stall_has_result, in_stall, out_valid,
                   "input stalled with no result pending")
  `WTPS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_probability_pct) && $stable(out_alert)
                   && $stable(out_lead_seconds) && $stable(out_eda_rising)
                   && $stable(out_temp_falling) && $stable(out_hr_rising),
                   "stalled result changed")

endmodule

bind windowed_trend_prodrome_scorer wtps_checker u_wtps_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the trend scorer, with its own slope and score model.
`timescale 1ns / 1ps

module tb
  import wtps_pkg::*;
();

  localparam int WIN = 600;
  localparam int IDLE_PCT = 29;
  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_GAP = 10;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam thr_t THR_MIN = 24'sh800000;
  localparam thr_t THR_MAX = 24'sh7FFFFF;

  // Least-squares constants over age index 0..WIN-1
  localparam longint N_L = WIN;
  localparam longint SX = N_L * (N_L - 1) / 2;
  localparam longint SXX = (N_L - 1) * N_L * (2 * N_L - 1) / 6;
  localparam longint DEN = N_L * SXX - SX * SX;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_SAMPLE;
  logic signed [15:0] in_temperature = '0;
  logic [15:0] in_conductance = '0;
  logic [11:0] in_heart_rate = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_alert;
  logic [6:0] out_probability_pct;
  logic [9:0] out_lead_seconds;
  logic out_eda_rising;
  logic out_temp_falling;
  logic out_hr_rising;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  windowed_trend_prodrome_scorer #(.WINDOW_LEN(WIN)) uut (.*);

  always #4 clk = ~clk;

  // Window model
  logic signed [15:0] temp_hist [WIN];
  logic [15:0] eda_hist [WIN];
  logic [11:0] hr_hist [WIN];
  int oldest_slot;
  longint lane_sum [NUM_LANES];
  longint lane_wsum [NUM_LANES];
  thr_t eda_thr, temp_thr, hr_thr;

  result_t pending_scores [$];
  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  function automatic void init_model();
    for (int i = 0; i < WIN; i++) begin
      temp_hist[i] = '0;
      eda_hist[i] = '0;
      hr_hist[i] = '0;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_sum[l] = 0;
      lane_wsum[l] = 0;
    end
    oldest_slot = 0;
    eda_thr = EDA_THR_RST;
    temp_thr = TEMP_THR_RST;
    hr_thr = HR_THR_RST;
  endfunction

  // Every surviving sample ages by one; the new one lands at the newest index
  function automatic void shift_lane(int lane, longint oldest, longint newest);
    lane_wsum[lane] = lane_wsum[lane] - (lane_sum[lane] - oldest) + (N_L - 1) * newest;
    lane_sum[lane] = lane_sum[lane] - oldest + newest;
  endfunction

  function automatic void absorb_sample(logic signed [15:0] t, logic [15:0] c, logic [11:0] h);
    shift_lane(LANE_TEMP, temp_hist[oldest_slot], t);
    shift_lane(LANE_EDA, eda_hist[oldest_slot], c);
    shift_lane(LANE_HR, hr_hist[oldest_slot], h);
    temp_hist[oldest_slot] = t;
    eda_hist[oldest_slot] = c;
    hr_hist[oldest_slot] = h;
    oldest_slot = (oldest_slot + 1 == WIN) ? 0 : oldest_slot + 1;
  endfunction

  function automatic longint slope_num(int lane);
    return N_L * lane_wsum[lane] - SX * lane_sum[lane];
  endfunction

  // Sign of slope*2^16 - thr, compared exactly as num*2^16 against thr*den
  function automatic int slope_vs_threshold(int lane, thr_t thr);
    logic signed [127:0] lhs, rhs;
    lhs = slope_num(lane);
    lhs = lhs * 65536;
    rhs = thr;
    rhs = rhs * DEN;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic longint slope_q16(int lane);
    logic signed [127:0] scaled;
    scaled = slope_num(lane);
    scaled = scaled * 65536;
    scaled = scaled / DEN;
    return longint'(scaled);
  endfunction

  function automatic result_t score_window();
    result_t r;
    logic er, tf, hr;
    logic [6:0] total;
    tf = slope_vs_threshold(LANE_TEMP, temp_thr) < 0;
    er = slope_vs_threshold(LANE_EDA, eda_thr) > 0;
    hr = slope_vs_threshold(LANE_HR, hr_thr) > 0;
    total = (er ? SCORE_EDA : 7'd0) + (tf ? SCORE_TEMP : 7'd0) + (hr ? SCORE_HR : 7'd0);
    r.alert = total > ALERT_LEVEL;
    r.probability_pct = r.alert ? total : total >> 1;
    r.lead_seconds = 10'(r.probability_pct) * LEAD_PER_PCT;
    r.eda_rising = er;
    r.temp_falling = tf;
    r.hr_rising = hr;
    return r;
  endfunction

  function automatic thr_t pick_threshold(int lane);
    longint v;
    case ($urandom_range(9))
      0: return THR_MIN;
      1: return THR_MAX;
      2: return thr_t'($urandom);
      default: begin
        // land near the present slope so that the trend ahead crosses it
        v = slope_q16(lane) + longint'($urandom_range(4000)) - 2000;
        if (v > THR_MAX) v = THR_MAX;
        if (v < THR_MIN) v = THR_MIN;
        return thr_t'(v);
      end
    endcase
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: result with no evaluate outstanding, expected none, got alert %0b pct %0d",
                 $time, out_alert, out_probability_pct);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        check_field("alert", want.alert, out_alert);
        check_field("probability_pct", want.probability_pct, out_probability_pct);
        check_field("lead_seconds", want.lead_seconds, out_lead_seconds);
        check_field("eda_rising", want.eda_rising, out_eda_rising);
        check_field("temp_falling", want.temp_falling, out_temp_falling);
        check_field("hr_rising", want.hr_rising, out_hr_rising);
      end
    end
  end

  always @(negedge clk) out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_reading(input logic cmd, input logic signed [15:0] t,
                              input logic [15:0] c, input logic [11:0] h);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_temperature <= t;
    in_conductance <= c;
    in_heart_rate <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_EVAL) pending_scores.push_back(score_window());
    else absorb_sample(t, c, h);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, drain results, then give trailing samples time to retire
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [REG_IDX_W-1:0] idx, input thr_t value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {8'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_EDA_THR: eda_thr = value;
      REG_TEMP_THR: temp_thr = value;
      REG_HR_THR: hr_thr = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input thr_t eda, input thr_t temp, input thr_t hr);
    write_threshold(REG_EDA_THR, eda);
    write_threshold(REG_TEMP_THR, temp);
    write_threshold(REG_HR_THR, hr);
  endtask

  task automatic test_reset_window();
    // zeros left by reset count as samples
    send_reading(CMD_EVAL, '0, '0, '0);
    settle();
    // flat window against zero thresholds: exact tie, no flag
    set_thresholds(thr_t'(0), thr_t'(0), thr_t'(0));
    send_reading(CMD_EVAL, 16'sh7FFF, 16'hFFFF, 12'hFFF);
    settle();
    set_thresholds(thr_t'(-1), thr_t'(1), thr_t'(-1));
    send_reading(CMD_EVAL, 16'sh8000, 16'h0000, 12'h000);
  endtask

  task automatic test_extreme_samples();
    send_reading(CMD_SAMPLE, 16'sh8000, 16'h0000, 12'h000);
    send_reading(CMD_SAMPLE, 16'sh7FFF, 16'hFFFF, 12'hFFF);
    send_reading(CMD_SAMPLE, 16'shFFFF, 16'h0001, 12'h001);
    send_reading(CMD_SAMPLE, 16'sh5555, 16'hAAAA, 12'h555);
    send_reading(CMD_SAMPLE, 16'shAAAA, 16'h5555, 12'hAAA);
    // sample fields of an evaluate are ignored
    send_reading(CMD_EVAL, 16'sh7FFF, 16'hFFFF, 12'hFFF);
  endtask

  task automatic test_flag_combinations();
    for (int combo = 0; combo < 8; combo++) begin
      settle();
      set_thresholds(combo[0] ? THR_MIN : THR_MAX, combo[1] ? THR_MAX : THR_MIN,
                     combo[2] ? THR_MIN : THR_MAX);
      send_reading(CMD_EVAL, 16'($urandom), 16'($urandom), 12'($urandom));
    end
    // index past the register map: write is dropped
    settle();
    write_threshold(REG_UNUSED, THR_MAX);
    send_reading(CMD_EVAL, 16'($urandom), 16'($urandom), 12'($urandom));
  endtask

  task automatic test_random_trends();
    int round, burst, spread;
    int temp_lvl, eda_lvl, hr_lvl, temp_step, eda_step, hr_step;
    round = 0;
    temp_lvl = 0;
    eda_lvl = 30000;
    hr_lvl = 1200;
    while (items_sent < ITEM_TARGET) begin
      no_idle = (round >= 8 && round < 13);
      settle();
      set_thresholds(pick_threshold(LANE_EDA), pick_threshold(LANE_TEMP),
                     pick_threshold(LANE_HR));
      spread = ($urandom_range(9) == 0) ? 300 : 12;
      temp_step = int'($urandom_range(2 * spread)) - spread;
      eda_step = int'($urandom_range(2 * spread)) - spread;
      hr_step = int'($urandom_range(2 * spread)) - spread;
      burst = $urandom_range(60, 20);
      repeat (burst) begin
        if ($urandom_range(99) < 25) begin
          send_reading(CMD_EVAL, 16'($urandom), 16'($urandom), 12'($urandom));
        end else if ($urandom_range(99) < 8) begin
          send_reading(CMD_SAMPLE, 16'($urandom), 16'($urandom), 12'($urandom));
        end else begin
          // advance each trend by its step plus a little noise
          temp_lvl = clamp(temp_lvl + temp_step + int'($urandom_range(6)) - 3, -32768, 32767);
          eda_lvl = clamp(eda_lvl + eda_step + int'($urandom_range(6)) - 3, 0, 65535);
          hr_lvl = clamp(hr_lvl + hr_step + int'($urandom_range(6)) - 3, 0, 4095);
          send_reading(CMD_SAMPLE, 16'(temp_lvl), 16'(eda_lvl), 12'(hr_lvl));
        end
      end
      round++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    init_model();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_extreme_samples();
    test_flag_combinations();
    test_random_trends();
    settle();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
